// File: rtl/core/bmsd_pkg.sv
`default_nettype none
package bmsd_pkg;

   // item field widths
   localparam int CAN_ID_W  = 29;
   localparam int DLC_W     = 4;
   localparam int PAYLOAD_W = 64;
   localparam int SEL_W     = 7;
   localparam int VALUE_W   = 16;
   localparam int BYTE_W    = 8;

   // store geometry
   localparam int NUM_CELLS   = 48;
   localparam int NUM_TEMPS   = 24;
   localparam int NUM_SUMMARY = 6;
   localparam int NUM_META    = 8;
   localparam int CODE_DEPTH  = NUM_CELLS + NUM_TEMPS + NUM_SUMMARY;
   localparam int ADDR_W      = $clog2(CODE_DEPTH + NUM_META);
   localparam int META_IDX_W  = $clog2(NUM_META);
   localparam int WORDS_PER_FRAME = 4;
   localparam int WCNT_W      = $clog2(WORDS_PER_FRAME);
   localparam int NWR_W       = WCNT_W + 1;

   // word store address map
   localparam logic [ADDR_W-1:0] TEMP_BASE = ADDR_W'(NUM_CELLS);
   localparam logic [ADDR_W-1:0] PACK_BASE = ADDR_W'(NUM_CELLS + NUM_TEMPS);
   localparam logic [ADDR_W-1:0] TSUM_BASE = ADDR_W'(NUM_CELLS + NUM_TEMPS + 3);
   localparam logic [ADDR_W-1:0] META_BASE = ADDR_W'(CODE_DEPTH);

   // frame identifiers
   localparam logic [CAN_ID_W-1:0] CELL_FIRST  = 29'h18110181;
   localparam logic [CAN_ID_W-1:0] CELL_LAST   = 29'h18110C81;
   localparam logic [CAN_ID_W-1:0] TEMP_FIRST  = 29'h18120181;
   localparam logic [CAN_ID_W-1:0] TEMP_LAST   = 29'h18120681;
   localparam logic [CAN_ID_W-1:0] ID_PACK     = 29'h18130181;
   localparam logic [CAN_ID_W-1:0] ID_COUNTS   = 29'h18130281;
   localparam logic [CAN_ID_W-1:0] ID_TEMPSUM  = 29'h18130381;
   localparam logic [CAN_ID_W-1:0] ID_RESERVED = 29'h18130481;
   localparam int ID_STEP_SHIFT = 8;

   localparam logic [DLC_W-1:0] DLC_FULL   = 4'd8;
   localparam logic [DLC_W-1:0] DLC_COUNTS = 4'd6;

   localparam logic ACTION_FRAME = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // write plan for one decoded frame
   typedef struct packed {
      logic              matched;
      logic [NWR_W-1:0]  nwrites;
      logic [ADDR_W-1:0] base;
      logic              word_remap;
      logic              meta_pack;
      logic              meta_counts;
   } plan_type;

   // sequencer to store controls
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               meta_pack;
      logic               meta_counts;
      logic               rd_en;
      logic [SEL_W-1:0]   rd_sel;
   } store_ctl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               known;
   } rd_type;

endpackage
`default_nettype wire

// File: rtl/core/bmsd_if.sv
`default_nettype none
interface bmsd_req_if;
   import bmsd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [CAN_ID_W-1:0]  can_id;
   logic [DLC_W-1:0]     dlc;
   logic [PAYLOAD_W-1:0] payload;
   logic [SEL_W-1:0]     read_select;

   modport source (output valid, action, can_id, dlc, payload, read_select, input ready);
   modport sink (input valid, action, can_id, dlc, payload, read_select, output ready);
endinterface

interface bmsd_rsp_if;
   import bmsd_pkg::*;

   logic               valid;
   logic               ready;
   logic               frame_matched;
   logic [VALUE_W-1:0] read_value;
   logic               read_known;

   modport source (output valid, frame_matched, read_value, read_known, input ready);
   modport sink (input valid, frame_matched, read_value, read_known, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bms_can_frame_decoder.sv
`default_nettype none
// channel    | dir | transfer carries
// -----------+-----+---------------------------------------------------
// req_bus    | in  | action, can_id, dlc, payload, read_select
// rsp_bus    | out | frame_matched, read_value, read_known (one per item)
//
// one item at a time; req_bus.ready is high only while the sequencer is idle
// frame: decode, then one store write per word (0, 3 or 4), then the response
// read: store read, then result load, then the response
// the word store has one write port; the decode plan sets the write count
// synchronous reset clears received flags and meta bytes; rsp stalls hold
module bms_can_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   bmsd_req_if.sink    req_bus,
   bmsd_rsp_if.source  rsp_bus
);
   import bmsd_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_LOAD   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]           state_ff,   state_in;

   // captured item
   logic                 act_ff,     act_in;
   logic [CAN_ID_W-1:0]  id_ff,      id_in;
   logic [DLC_W-1:0]     dlc_ff,     dlc_in;
   logic [PAYLOAD_W-1:0] pay_ff,     pay_in;
   logic [SEL_W-1:0]     sel_ff,     sel_in;

   // write plan and word counter
   logic [ADDR_W-1:0]    base_ff,    base_in;
   logic [NWR_W-1:0]     nwr_ff,     nwr_in;
   logic                 remap_ff,   remap_in;
   logic [WCNT_W-1:0]    cnt_ff,     cnt_in;

   // response register
   logic                 matched_ff, matched_in;
   logic [VALUE_W-1:0]   value_ff,   value_in;
   logic                 known_ff,   known_in;

   logic                 req_xfer;
   logic                 last_write;
   logic [WCNT_W-1:0]    word_sel;
   logic [VALUE_W-1:0]   word;
   plan_type             plan;
   store_ctl_type        ctl;
   rd_type               rd;

   bmsd_decode u_decode (
      .can_id (id_ff),
      .dlc    (dlc_ff),
      .plan   (plan)
   );

   bmsd_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .payload (pay_ff),
      .rd      (rd)
   );

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign req_xfer              = req_bus.valid & req_bus.ready;
   assign rsp_bus.valid         = (state_ff == S_RESP);
   assign rsp_bus.frame_matched = matched_ff;
   assign rsp_bus.read_value    = value_ff;
   assign rsp_bus.read_known    = known_ff;

   // word pick for the current write, pack frame skips word 2
   always_comb begin
      word_sel   = (remap_ff && cnt_ff == WCNT_W'(2)) ? WCNT_W'(3) : cnt_ff;
      last_write = (NWR_W'(cnt_ff) + NWR_W'(1)) == nwr_ff;
      case (word_sel)
         2'd0:    word = pay_ff[63:48];
         2'd1:    word = pay_ff[47:32];
         2'd2:    word = pay_ff[31:16];
         default: word = pay_ff[15:0];
      endcase
   end

   // store controls
   always_comb begin
      ctl             = '0;
      ctl.wr_en       = (state_ff == S_WRITE);
      ctl.wr_addr     = base_ff + ADDR_W'(cnt_ff);
      ctl.wr_data     = word;
      ctl.meta_pack   = (state_ff == S_DECODE) && plan.meta_pack;
      ctl.meta_counts = (state_ff == S_DECODE) && plan.meta_counts;
      ctl.rd_en       = (state_ff == S_READ);
      ctl.rd_sel      = sel_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      id_in      = id_ff;
      dlc_in     = dlc_ff;
      pay_in     = pay_ff;
      sel_in     = sel_ff;
      base_in    = base_ff;
      nwr_in     = nwr_ff;
      remap_in   = remap_ff;
      cnt_in     = cnt_ff;
      matched_in = matched_ff;
      value_in   = value_ff;
      known_in   = known_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in   = req_bus.action;
               id_in    = req_bus.can_id;
               dlc_in   = req_bus.dlc;
               pay_in   = req_bus.payload;
               sel_in   = req_bus.read_select;
               state_in = (req_bus.action == ACTION_READ) ? S_READ : S_DECODE;
            end
         end
         S_DECODE: begin
            // meta bytes land this cycle, words follow one per cycle
            base_in    = plan.base;
            nwr_in     = plan.nwrites;
            remap_in   = plan.word_remap;
            cnt_in     = '0;
            matched_in = plan.matched;
            value_in   = '0;
            known_in   = 1'b0;
            state_in   = (plan.nwrites != '0) ? S_WRITE : S_RESP;
         end
         S_WRITE: begin
            cnt_in = cnt_ff + WCNT_W'(1);
            if (last_write) begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            matched_in = 1'b0;
            value_in   = rd.value;
            known_in   = rd.known;
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      id_ff      <= id_in;
      dlc_ff     <= dlc_in;
      pay_ff     <= pay_in;
      sel_ff     <= sel_in;
      base_ff    <= base_in;
      nwr_ff     <= nwr_in;
      remap_ff   <= remap_in;
      matched_ff <= matched_in;
      value_ff   <= value_in;
      known_ff   <= known_in;
   end

endmodule
`default_nettype wire

// File: rtl/core/bmsd_decode.sv
`default_nettype none
module bmsd_decode (
   input  logic [bmsd_pkg::CAN_ID_W-1:0] can_id,
   input  logic [bmsd_pkg::DLC_W-1:0]    dlc,
   output bmsd_pkg::plan_type            plan
);
   import bmsd_pkg::*;

   logic                is_cell;
   logic                is_temp;
   logic                is_pack;
   logic                is_counts;
   logic                is_tsum;
   logic                is_resv;
   logic [CAN_ID_W-1:0] first_id;
   logic [CAN_ID_W-1:0] id_diff;
   logic [3:0]          group;
   logic [ADDR_W-1:0]   group_base;

   always_comb begin
      is_cell   = (can_id inside {[CELL_FIRST:CELL_LAST]}) && (dlc == DLC_FULL);
      is_temp   = (can_id inside {[TEMP_FIRST:TEMP_LAST]}) && (dlc == DLC_FULL);
      is_pack   = (can_id == ID_PACK) && (dlc >= DLC_FULL);
      is_counts = (can_id == ID_COUNTS) && (dlc >= DLC_COUNTS);
      is_tsum   = (can_id == ID_TEMPSUM) && (dlc >= DLC_FULL);
      is_resv   = (can_id == ID_RESERVED);

      // ranges are disjoint, so one subtractor serves both
      first_id   = is_temp ? TEMP_FIRST : CELL_FIRST;
      id_diff    = can_id - first_id;
      group      = id_diff[ID_STEP_SHIFT+3:ID_STEP_SHIFT];
      group_base = ADDR_W'({group, 2'b00});

      plan             = '0;
      plan.matched     = is_cell | is_temp | is_pack | is_counts | is_tsum | is_resv;
      plan.meta_pack   = is_pack;
      plan.meta_counts = is_counts;
      if (is_cell) begin
         plan.nwrites = NWR_W'(WORDS_PER_FRAME);
         plan.base    = group_base;
      end else if (is_temp) begin
         plan.nwrites = NWR_W'(WORDS_PER_FRAME);
         plan.base    = TEMP_BASE + group_base;
      end else if (is_pack) begin
         // pack voltage sits in word 3, not word 2
         plan.nwrites    = NWR_W'(3);
         plan.base       = PACK_BASE;
         plan.word_remap = 1'b1;
      end else if (is_tsum) begin
         plan.nwrites = NWR_W'(3);
         plan.base    = TSUM_BASE;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bmsd_store.sv
`default_nettype none
module bmsd_store (
   input  logic                           clock,
   input  logic                           reset,
   input  bmsd_pkg::store_ctl_type        ctl,
   input  logic [bmsd_pkg::PAYLOAD_W-1:0] payload,
   output bmsd_pkg::rd_type               rd
);
   import bmsd_pkg::*;

   localparam logic [1:0] CLS_NONE = 2'd0;
   localparam logic [1:0] CLS_CODE = 2'd1;
   localparam logic [1:0] CLS_META = 2'd2;

   logic [VALUE_W-1:0]    code_mem [CODE_DEPTH];
   logic [CODE_DEPTH-1:0] known_ff;
   logic [BYTE_W-1:0]     meta_ff  [NUM_META];

   logic [VALUE_W-1:0]    rd_code_ff;
   logic                  rd_bit_ff;
   logic [BYTE_W-1:0]     rd_meta_ff;
   logic [1:0]            rd_cls_ff;

   logic [1:0]            cls;
   logic [ADDR_W-1:0]     meta_off;
   logic [META_IDX_W-1:0] meta_idx;

   always_comb begin
      meta_off = ctl.rd_sel - META_BASE;
      meta_idx = meta_off[META_IDX_W-1:0];
      if (ctl.rd_sel < META_BASE) begin
         cls = CLS_CODE;
      end else if (ctl.rd_sel < META_BASE + ADDR_W'(NUM_META)) begin
         cls = CLS_META;
      end else begin
         cls = CLS_NONE;
      end
   end

   // word store, one write port, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         code_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_code_ff <= code_mem[ctl.rd_sel];
         rd_meta_ff <= meta_ff[meta_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         rd_bit_ff <= 1'b0;
         rd_cls_ff <= CLS_NONE;
      end else begin
         if (ctl.wr_en) begin
            known_ff[ctl.wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_bit_ff <= (cls == CLS_CODE) ? known_ff[ctl.rd_sel] : 1'b0;
            rd_cls_ff <= cls;
         end
      end
   end

   // meta bytes, big-endian byte 0 in the top of the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_META; i++) begin
            meta_ff[i] <= '0;
         end
      end else begin
         if (ctl.meta_pack) begin
            meta_ff[0] <= payload[PAYLOAD_W-1-4*BYTE_W -: BYTE_W];
            meta_ff[1] <= payload[PAYLOAD_W-1-5*BYTE_W -: BYTE_W];
         end
         if (ctl.meta_counts) begin
            for (int k = 0; k < 6; k++) begin
               meta_ff[2+k] <= payload[PAYLOAD_W-1-k*BYTE_W -: BYTE_W];
            end
         end
      end
   end

   always_comb begin
      case (rd_cls_ff)
         CLS_CODE: begin
            rd.known = rd_bit_ff;
            rd.value = rd_bit_ff ? rd_code_ff : '0;
         end
         CLS_META: begin
            rd.known = 1'b1;
            rd.value = VALUE_W'(rd_meta_ff);
         end
         default: begin
            rd.known = 1'b0;
            rd.value = '0;
         end
      endcase
   end

endmodule
`default_nettype wire
